// ===== design/pt4_pkg.sv =====
// ----------------------------------------------------------------------------
// pt4_pkg
// Shared types and constants of the 4x4 point transform: payload structs,
// field widths, fixed-point formats and request codes.
// ----------------------------------------------------------------------------
package pt4_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 16;
  localparam int COEF_FRAC   = 12;
  localparam int COORD_FRAC  = 16;
  localparam int ROW_WIDTH   = 64;
  localparam int COL_PITCH   = 16;

  // product, column sum, divider numerator and divisor widths
  localparam int PRW = COORD_WIDTH + COEF_WIDTH;
  localparam int CSW = COORD_WIDTH + COEF_WIDTH + 2;
  localparam int NW  = CSW + COORD_FRAC + 1;
  localparam int DW  = CSW + 1;
  localparam int QW  = COORD_WIDTH;

  localparam logic [1:0] REQ_HOMOG  = 2'd0;
  localparam logic [1:0] REQ_AFFINE = 2'd1;

  localparam logic [1:0] REG_ROW0 = 2'd0;
  localparam logic [1:0] REG_ROW1 = 2'd1;
  localparam logic [1:0] REG_ROW2 = 2'd2;
  localparam logic [1:0] REG_ROW3 = 2'd3;

  typedef logic [ROW_WIDTH-1:0] row_t;
  typedef logic signed [CSW-1:0] csum_t;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          zero_divisor;
    logic                          saturated;
  } out_t;

  // per-item control carried alongside the divider
  typedef struct packed {
    logic                          homog;
    logic                          zero;
    logic [2:0]                    neg;
    logic [2:0][COORD_WIDTH-1:0]   lin;
    logic                          lin_sat;
  } side_t;

endpackage

// ===== design/pt4_mac.sv =====
// ----------------------------------------------------------------------------
// pt4_mac
// Two-stage multiply-accumulate: twelve coefficient products, then the four
// column sums in Q.28 with the translation row added in homogeneous and
// affine modes.
// ----------------------------------------------------------------------------
module pt4_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  pt4_pkg::in_t        in_data,
  input  pt4_pkg::row_t [3:0] rows,
  output logic                sum_valid,
  output logic [1:0]          sum_mode,
  output pt4_pkg::csum_t [3:0] sums
);
  import pt4_pkg::*;

  logic signed [PRW-1:0] prod_r [4][3];
  logic signed [PRW-1:0] prod_nxt [4][3];
  csum_t                 tr_r [4];
  csum_t                 tr_nxt [4];
  logic [1:0]            mode_r;
  logic                  va_r;
  csum_t [3:0]           sum_r;
  csum_t [3:0]           sum_nxt;
  logic [1:0]            mode2_r;
  logic                  vb_r;
  logic signed [COORD_WIDTH-1:0] pt [3];

  assign pt[0] = in_data.in_x;
  assign pt[1] = in_data.in_y;
  assign pt[2] = in_data.in_z;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_nxt[c][r] = PRW'(pt[r]) *
                         PRW'($signed(rows[r][c*COL_PITCH +: COEF_WIDTH]));
      end
      tr_nxt[c] = CSW'($signed(rows[3][c*COL_PITCH +: COEF_WIDTH])) <<< COORD_FRAC;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_nxt[c] = CSW'(prod_r[c][0]) + CSW'(prod_r[c][1]) + CSW'(prod_r[c][2]) +
                   ((mode_r == REQ_HOMOG || mode_r == REQ_AFFINE) ? tr_r[c] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      tr_r    <= tr_nxt;
      mode_r  <= in_data.req_type;
      sum_r   <= sum_nxt;
      mode2_r <= mode_r;
    end
  end

  assign sum_valid = vb_r;
  assign sum_mode  = mode2_r;
  assign sums      = sum_r;

endmodule

// ===== design/pt4_div.sv =====
// ----------------------------------------------------------------------------
// pt4_div
// Pipelined restoring divider, one quotient bit per stage. A first stage
// flags quotients that do not fit in QW bits and seeds the remainder.
// ----------------------------------------------------------------------------
module pt4_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [pt4_pkg::NW-1:0]   num,
  input  logic [pt4_pkg::DW-1:0]   den,
  output logic [pt4_pkg::QW-1:0]   quo,
  output logic                     ovf
);
  import pt4_pkg::*;

  localparam int PW = DW + QW;

  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] rem_nxt [QW+1];
  logic [QW-1:0] nl_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [QW-1:0] q_nxt [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [DW:0]   trial [QW];
  logic [DW:0]   diff  [QW];

  always_comb begin
    rem_nxt[0] = DW'(num >> QW);
    q_nxt[0]   = '0;
    for (int k = 0; k < QW; k++) begin
      trial[k] = {rem_r[k], nl_r[k][QW-1-k]};
      diff[k]  = trial[k] - {1'b0, d_r[k]};
      q_nxt[k+1] = q_r[k];
      if (trial[k] >= {1'b0, d_r[k]}) begin
        rem_nxt[k+1] = diff[k][DW-1:0];
        q_nxt[k+1][QW-1-k] = 1'b1;
      end else begin
        rem_nxt[k+1] = trial[k][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem_nxt[0];
      nl_r[0]  <= num[QW-1:0];
      d_r[0]   <= den;
      q_r[0]   <= q_nxt[0];
      ovf_r[0] <= PW'(num) >= {den, {QW{1'b0}}};
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1] <= rem_nxt[k+1];
        nl_r[k+1]  <= nl_r[k];
        d_r[k+1]   <= d_r[k];
        q_r[k+1]   <= q_nxt[k+1];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ===== design/point_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// point_transform_4x4
// Row-vector times 4x4 matrix transform of a Q16.16 point with optional
// perspective divide, rounding and saturation to Q16.16.
// ----------------------------------------------------------------------------
// The divider pipeline resolves one quotient bit per stage. Throughput: one
// transfer per cycle while a held result is not stalled.
// The whole pipeline advances unless a held result is stalled.
// Reset clears the matrix registers and all valid bits.
module point_transform_4x4 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pt4_pkg::in_t     in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pt4_pkg::out_t    out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  pt4_pkg::row_t    cfg_data
);
  import pt4_pkg::*;

  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  row_t [3:0]  rows_r;
  logic        adv;
  logic        sum_valid;
  logic [1:0]  sum_mode;
  csum_t [3:0] sums;

  side_t         side_nxt;
  side_t         side_r [QW+2];
  logic          vld_r  [QW+2];
  logic [NW-1:0] num_nxt [3];
  logic [NW-1:0] num_r   [3];
  logic [DW-1:0] den_nxt;
  logic [DW-1:0] den_r;
  logic [CSW-1:0] aden;
  logic [CSW-1:0] anum [3];
  csum_t          rnd  [3];
  logic [QW-1:0]  quo [3];
  logic           ovf [3];
  logic [CSW-COORD_WIDTH:0] top_bits [3];

  out_t out_nxt;
  out_t out_r;
  logic out_valid_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW0: rows_r[0] <= cfg_data;
        REG_ROW1: rows_r[1] <= cfg_data;
        REG_ROW2: rows_r[2] <= cfg_data;
        REG_ROW3: rows_r[3] <= cfg_data;
        default:  rows_r[0] <= cfg_data;
      endcase
    end
  end

  pt4_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .rows      (rows_r),
    .sum_valid (sum_valid),
    .sum_mode  (sum_mode),
    .sums      (sums)
  );

  always_comb begin
    aden = sums[3][CSW-1] ? CSW'(-sums[3]) : CSW'(sums[3]);
    den_nxt = {aden, 1'b0};
    side_nxt.homog = (sum_mode == REQ_HOMOG);
    side_nxt.zero  = (sums[3] == '0);
    side_nxt.lin_sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      anum[c] = sums[c][CSW-1] ? CSW'(-sums[c]) : CSW'(sums[c]);
      num_nxt[c] = (NW'(anum[c]) << (COORD_FRAC + 1)) + NW'(aden);
      side_nxt.neg[c] = sums[c][CSW-1] ^ sums[3][CSW-1];
      rnd[c] = (sums[c] + CSW'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
      top_bits[c] = rnd[c][CSW-1:COORD_WIDTH-1];
      if ((&top_bits[c]) || !(|top_bits[c])) begin
        side_nxt.lin[c] = rnd[c][COORD_WIDTH-1:0];
      end else begin
        side_nxt.lin[c] = rnd[c][CSW-1] ? CMIN : CMAX;
        side_nxt.lin_sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW + 2; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= sum_valid;
      for (int k = 1; k < QW + 2; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < QW + 2; k++) side_r[k] <= side_r[k-1];
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    pt4_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num_r[c]),
      .den (den_r),
      .quo (quo[c]),
      .ovf (ovf[c])
    );
  end

  always_comb begin
    logic [2:0][COORD_WIDTH-1:0] res;
    logic sat;
    res = side_r[QW+1].lin;
    sat = side_r[QW+1].lin_sat;
    if (side_r[QW+1].homog) begin
      sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
        if (side_r[QW+1].zero) begin
          res[c] = '0;
        end else if (side_r[QW+1].neg[c]) begin
          if (ovf[c] || quo[c] > CMIN) begin
            res[c] = CMIN;
            sat = 1'b1;
          end else begin
            res[c] = COORD_WIDTH'(-quo[c]);
          end
        end else begin
          if (ovf[c] || quo[c][QW-1]) begin
            res[c] = CMAX;
            sat = 1'b1;
          end else begin
            res[c] = quo[c];
          end
        end
      end
    end
    out_nxt.out_x        = res[0];
    out_nxt.out_y        = res[1];
    out_nxt.out_z        = res[2];
    out_nxt.zero_divisor = side_r[QW+1].homog && side_r[QW+1].zero;
    out_nxt.saturated    = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[QW+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/pt4_checker.sv =====
// ----------------------------------------------------------------------------
// pt4_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
module pt4_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input pt4_pkg::out_t out_data
);
  import pt4_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_divisor |->
      !out_data.saturated && out_data.out_x == '0 &&
      out_data.out_y == '0 && out_data.out_z == '0)
    else $error("zero divisor result not cleared");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_transform_4x4 pt4_checker u_pt4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/tb_point_transform_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_transform_4x4
// Self-checking bench for the 4x4 point transform. An in-bench model computes
// every transformed point at 128-bit precision and queues it. Each result
// transfer is then checked field by field against the oldest queued point.
// Directed points cover extremes, every request type, rounding ties, zero
// divisors and saturation. Random points then run under several matrices,
// with random idling on both sides, one long receiver hold-off and a full
// drain after each run.
// ----------------------------------------------------------------------------
module tb_point_transform_4x4;
  import pt4_pkg::*;

  localparam logic [1:0] REQ_LINEAR = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;
  localparam logic [15:0] Q_ONE     = 16'h1000;
  localparam int CYCLE_LIMIT        = 200000;
  localparam int DRAIN_CYCLES       = 45;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [1:0] cfg_index = REG_ROW0;
  row_t  cfg_data = '0;

  row_t  matrix [4];
  out_t  expected_points [$];
  int    mismatches = 0;
  int    points_checked = 0;
  int    points_sent = 0;
  int    cycles = 0;
  bit    tx_idle_en = 1'b0;
  bit    rx_idle_en = 1'b0;
  int    rx_hold = 0;
  int    rx_burst = 0;

  point_transform_4x4 uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles,
               expected_points.size());
      $display("tb_point_transform_4x4: FAIL");
      $finish;
    end
  end

  // receiver: long hold-off has priority, then random stall bursts when enabled
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (!rx_idle_en) begin
      out_stall <= 1'b0;
    end else if (rx_burst > 0) begin
      out_stall <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_burst <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [127:0] coef(int r, int c);
    logic signed [15:0] raw;
    raw = matrix[r][16*c +: 16];
    return raw;
  endfunction

  function automatic logic signed [127:0] column_sum(in_t p, int c, bit with_t);
    logic signed [127:0] px, py, pz, acc;
    px = p.in_x;
    py = p.in_y;
    pz = p.in_z;
    acc = px * coef(0, c) + py * coef(1, c) + pz * coef(2, c);
    if (with_t) acc = acc + coef(3, c) * 128'sd65536;
    return acc;
  endfunction

  function automatic logic [31:0] clip_coord(logic signed [127:0] v, ref bit sat);
    logic signed [127:0] hi, lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    return v[31:0];
  endfunction

  function automatic out_t transform_point(in_t p);
    out_t r;
    logic signed [127:0] den, num, q, v;
    logic signed [127:0] coords [3];
    bit dneg, neg, sat;
    r = '0;
    sat = 1'b0;
    if (p.req_type == REQ_HOMOG) begin
      den = column_sum(p, 3, 1'b1);
      if (den == 0) begin
        r.zero_divisor = 1'b1;
        return r;
      end
      dneg = den < 0;
      if (dneg) den = -den;
      for (int c = 0; c < 3; c++) begin
        num = column_sum(p, c, 1'b1);
        neg = (num < 0) != dneg;
        if (num < 0) num = -num;
        q = ((num <<< 17) + den) / (den <<< 1);
        coords[c] = neg ? -q : q;
      end
    end else begin
      for (int c = 0; c < 3; c++) begin
        v = column_sum(p, c, p.req_type == REQ_AFFINE);
        coords[c] = (v + 128'sd2048) >>> 12;
      end
    end
    r.out_x = clip_coord(coords[0], sat);
    r.out_y = clip_coord(coords[1], sat);
    r.out_z = clip_coord(coords[2], sat);
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", out_data);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_z !== want.out_z ||
            out_data.zero_divisor !== want.zero_divisor ||
            out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p, got %p",
                     points_checked, want, out_data);
        end
      end
    end
  end

  task automatic write_row(logic [1:0] idx, row_t val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    matrix[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(row_t r0, row_t r1, row_t r2, row_t r3);
    write_row(REG_ROW0, r0);
    write_row(REG_ROW1, r1);
    write_row(REG_ROW2, r2);
    write_row(REG_ROW3, r3);
  endtask

  // leaves in_valid high; caller follows with another send or tx_stop
  task automatic send_point(logic [1:0] req, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
    in_t p;
    p.req_type = req;
    p.in_x = x;
    p.in_y = y;
    p.in_z = z;
    in_data <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_points.push_back(transform_point(p));
    points_sent++;
  endtask

  task automatic tx_stop();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tx_gap();
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return $urandom;
      default: return $urandom_range(0, 16'h2000) - 16'h1000;
    endcase
  endfunction

  function automatic row_t rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      tx_gap();
      send_point($urandom_range(0, 7) == 0 ? REQ_SPARE : 2'($urandom_range(0, 2)),
                 rand_coord(), rand_coord(), rand_coord());
    end
    tx_stop();
  endtask

  task automatic test_directed();
    // identity with translation and unit scale
    load_matrix({16'h0, 16'h0, 16'h0, Q_ONE}, {16'h0, 16'h0, Q_ONE, 16'h0},
                {16'h0, Q_ONE, 16'h0, 16'h0}, {Q_ONE, 16'hF800, 16'h0800, 16'h1000});
    send_point(REQ_HOMOG, 32'h0, 32'h0, 32'h0);
    send_point(REQ_AFFINE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(REQ_AFFINE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(REQ_LINEAR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(REQ_SPARE, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1234_5678);
    send_point(REQ_HOMOG, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
    tx_stop();
    drain();
    // half scale: rounding ties, and divisor 2.0 for ties away from zero
    load_matrix({16'h0, 16'h0, 16'h0, 16'h0800}, {16'h0, 16'h0, 16'hF800, 16'h0},
                {16'h0, 16'h0800, 16'h0, 16'h0}, {16'h2000, 16'h0, 16'h0, 16'h0});
    send_point(REQ_LINEAR, 32'h1, 32'h1, 32'h1);
    send_point(REQ_LINEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(REQ_AFFINE, 32'h3, 32'h3, 32'hFFFF_FFFD);
    send_point(REQ_HOMOG, 32'h1, 32'hFFFF_FFFF, 32'h3);
    send_point(REQ_HOMOG, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFD);
    tx_stop();
    drain();
    // zero divisor column, full-scale coefficients to force saturation
    load_matrix({16'h0, 16'h8000, 16'h7FFF, 16'h7FFF}, {16'h0, 16'h7FFF, 16'h8000, 16'h7FFF},
                {16'h0, 16'h7FFF, 16'h7FFF, 16'h8000}, {16'h0, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_point(REQ_HOMOG, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    send_point(REQ_HOMOG, 32'h0, 32'h0, 32'h0);
    send_point(REQ_AFFINE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(REQ_LINEAR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(REQ_AFFINE, 32'h0, 32'h0, 32'h0);
    tx_stop();
    drain();
    // negative divisor, cancelling to zero only for some points
    load_matrix({16'h1000, 16'h0, 16'h0, Q_ONE}, {16'hF000, 16'h0, Q_ONE, 16'h0},
                {16'h0, Q_ONE, 16'h0, 16'h0}, {16'hF000, 16'h0, 16'h0, 16'h0});
    send_point(REQ_HOMOG, 32'h0001_0000, 32'h0, 32'h0);
    send_point(REQ_HOMOG, 32'h0, 32'h0, 32'h0005_0000);
    send_point(REQ_HOMOG, 32'h0, 32'h0001_0000, 32'h0002_0000);
    tx_stop();
    drain();
  endtask

  task automatic test_random_matrices();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    run_random(70);
    drain();
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    run_random(70);
    drain();
    load_matrix('0, '0, '0, '0);
    run_random(30);
    drain();
    load_matrix({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}});
    run_random(50);
    drain();
    for (int s = 0; s < 3; s++) begin
      load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
      run_random(60);
      drain();
    end
  endtask

  task automatic test_backpressure();
    load_matrix(rand_row(), rand_row(), rand_row(), {rand_coef(), 48'($urandom)});
    tx_idle_en = 1'b0;
    @(posedge clk);
    rx_hold <= 300;
    run_random(90);
    drain();
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
    run_random(60);
  endtask

  initial begin
    matrix = '{default: '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_matrices();
    test_backpressure();
    test_steady_stream();
    drain();
    $display("sent %0d points over all request types, checked %0d results", points_sent,
             points_checked);
    $display("matrices included all-zero, full-scale positive and negative, and random");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("tb_point_transform_4x4: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_points.size());
      $display("tb_point_transform_4x4: FAIL");
    end
    $finish;
  end

endmodule
